FILE: rtl/psc_pkg.sv
package psc_pkg;

    // table geometry and count width
    localparam int MAX_ENTRIES   = 256;
    localparam int MAX_ENTRY_LEN = 8;
    localparam int COUNT_BITS    = 48;

    localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
    localparam int LEN_AW   = (MAX_ENTRY_LEN > 1) ? $clog2(MAX_ENTRY_LEN) : 1;
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);

    // fixed field widths
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 4;
    localparam int WAYS_W     = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSSIBLE_ONLY  = 2'd1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_STREAM = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic              func;
        logic [7:0]        entry_index;
        logic [2:0]        char_pos;
        logic [LEN_W-1:0]  entry_length;
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } t_in_item;

    typedef struct packed {
        logic [WAYS_W-1:0] ways;
        logic              possible;
        logic              saturated;
    } t_out_item;

    typedef logic [MAX_ENTRY_LEN-1:0][CHAR_W-1:0] t_row;

    // controller to datapath
    typedef struct packed {
        logic                tbl_wr;
        logic                char_load;
        logic                rd_en;
        logic [ENTRY_AW-1:0] rd_addr;
        logic                commit;
        logic                last;
        logic                possible_only;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/psc_table.sv
module psc_table
    import psc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  t_in_item            i_wr_item,
    input  logic                i_rd_en,
    input  logic [ENTRY_AW-1:0] i_rd_addr,
    output t_row                o_rd_row,
    output logic [LEN_W-1:0]    o_rd_len
);

    t_row                r_chars [MAX_ENTRIES];
    logic [LEN_W-1:0]    r_lens  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_len_vld;
    t_row                r_rd_row;
    logic [LEN_W-1:0]    r_rd_len;
    logic                r_rd_vld;

    logic                idx_ok;
    logic                pos_ok;
    logic [ENTRY_AW-1:0] wr_addr;

    assign idx_ok  = int'(i_wr_item.entry_index) < MAX_ENTRIES;
    assign pos_ok  = int'(i_wr_item.char_pos) < MAX_ENTRY_LEN;
    assign wr_addr = ENTRY_AW'(i_wr_item.entry_index);

    // character rows, one byte lane per position
    always_ff @(posedge i_clk) begin
        if (i_wr_en && idx_ok && pos_ok) begin
            r_chars[wr_addr][LEN_AW'(i_wr_item.char_pos)] <= i_wr_item.char_code;
        end
        if (i_rd_en) begin
            r_rd_row <= r_chars[i_rd_addr];
        end
    end

    // entry lengths
    always_ff @(posedge i_clk) begin
        if (i_wr_en && idx_ok) begin
            r_lens[wr_addr] <= i_wr_item.entry_length;
        end
        if (i_rd_en) begin
            r_rd_len <= r_lens[i_rd_addr];
        end
    end

    // written flags, unwritten lengths read as unused
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
        end else begin
            if (i_wr_en && idx_ok) begin
                r_len_vld[wr_addr] <= 1'b1;
            end
        end
        if (i_rd_en) begin
            r_rd_vld <= r_len_vld[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_row;
    assign o_rd_len = r_rd_vld ? r_rd_len : '0;

endmodule

FILE: rtl/psc_datapath.sv
module psc_datapath
    import psc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [CHAR_W-1:0] i_char,
    input  t_row              i_rd_row,
    input  logic [LEN_W-1:0]  i_rd_len,
    output t_dp_stat          o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data
);

    logic [CHAR_W-1:0]     r_recent [MAX_ENTRY_LEN];
    logic [COUNT_BITS-1:0] r_hist   [MAX_ENTRY_LEN];
    logic [COUNT_BITS-1:0] r_term;
    logic [COUNT_BITS-1:0] r_sum;
    logic                  r_ovf;
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [MAX_ENTRY_LEN-1:0] match_len;
    logic                     len_ok;
    logic [LEN_AW-1:0]        len_idx;
    logic [COUNT_BITS-1:0]    n_term;
    logic [COUNT_BITS:0]      add_wide;
    logic                     nz;

    // suffix compare for every possible entry length
    always_comb begin
        for (int l = 1; l <= MAX_ENTRY_LEN; l++) begin
            match_len[l-1] = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (i_rd_row[j] != r_recent[l-1-j]) begin
                    match_len[l-1] = 1'b0;
                end
            end
        end
    end

    assign len_ok  = (i_rd_len != '0) && (i_rd_len <= LEN_W'(MAX_ENTRY_LEN));
    assign len_idx = LEN_AW'(i_rd_len - LEN_W'(1));
    assign n_term  = (len_ok && match_len[len_idx]) ? r_hist[len_idx] : '0;

    assign add_wide = {1'b0, r_sum} + {1'b0, r_term};
    assign nz       = r_sum != '0;

    // recent word characters, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.char_load) begin
            r_recent[0] <= i_char;
            for (int k = 1; k < MAX_ENTRY_LEN; k++) begin
                r_recent[k] <= r_recent[k-1];
            end
        end
        r_term <= n_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            for (int k = 0; k < MAX_ENTRY_LEN; k++) begin
                r_hist[k] <= (k == 0) ? COUNT_BITS'(1) : '0;
            end
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            if (i_cmd.char_load) begin
                r_sum <= '0;
            end else if (r_v2) begin
                if (add_wide[COUNT_BITS]) begin
                    r_sum <= COUNT_MAX;
                    r_ovf <= 1'b1;
                end else begin
                    r_sum <= add_wide[COUNT_BITS-1:0];
                end
            end
            if (i_cmd.commit) begin
                if (i_cmd.last) begin
                    // fresh word
                    for (int k = 0; k < MAX_ENTRY_LEN; k++) begin
                        r_hist[k] <= (k == 0) ? COUNT_BITS'(1) : '0;
                    end
                    r_ovf <= 1'b0;
                end else begin
                    r_hist[0] <= r_sum;
                    for (int k = 1; k < MAX_ENTRY_LEN; k++) begin
                        r_hist[k] <= r_hist[k-1];
                    end
                end
            end
            if (i_cmd.commit && i_cmd.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && i_cmd.last) begin
            r_out.ways      <= i_cmd.possible_only ? WAYS_W'(nz) : WAYS_W'(r_sum);
            r_out.possible  <= nz;
            r_out.saturated <= r_ovf;
        end
    end

    assign o_stat.busy     = r_v1 || r_v2;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

FILE: rtl/psc_ctrl.sv
module psc_ctrl
    import psc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_stat              i_stat,
    output t_dp_cmd               o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_scan;
    logic                  r_last;
    logic [CFG_DATA_W-1:0] r_entries;
    logic                  r_poss_only;

    logic             accept;
    logic [CNT_W-1:0] n_scan;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign n_scan      = (int'(r_entries) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(r_entries);

    always_comb begin
        o_cmd.tbl_wr        = accept && (i_in_data.func == FUNC_LOAD);
        o_cmd.char_load     = accept && (i_in_data.func == FUNC_STREAM);
        o_cmd.rd_en         = (r_state == S_SCAN) && (r_cnt < r_scan);
        o_cmd.rd_addr       = r_cnt[ENTRY_AW-1:0];
        o_cmd.commit        = (r_state == S_FINISH) && (!r_last || i_stat.out_free);
        o_cmd.last          = r_last;
        o_cmd.possible_only = r_poss_only;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entries   <= '0;
            r_poss_only <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ENTRIES_IN_USE: r_entries   <= i_cfg_data;
                    CFG_POSSIBLE_ONLY:  r_poss_only <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.char_load) begin
                        r_cnt   <= '0;
                        r_scan  <= n_scan;
                        r_last  <= i_in_data.last_char;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt < r_scan) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!i_stat.busy) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (o_cmd.commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/pattern_segmentation_counter_unit.sv
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-----------------------------
// in        | in        | i_in_valid / o_in_ready    | i_in_data (t_in_item)
// out       | out       | o_out_valid / i_out_ready  | o_out_data (t_out_item)
// cfg       | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a load transaction writes the table when it is accepted; a word character walks N
// table entries, where N is entries_in_use capped at the table size, one table entry per
// cycle through the single read port of the pattern memory, plus read, add,
// drain and commit stages
// reset is synchronous active low and takes effect at once, no clearing pass
// a result waits in the output register while the next character is scanned;
// a last character stalls only if the previous result is still not taken
module pattern_segmentation_counter_unit
    import psc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item stream
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    t_row             rd_row;
    logic [LEN_W-1:0] rd_len;

    // sequencer: accepts transactions, walks the table, commits each position
    psc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // pattern memory: one row of characters and a length per entry
    psc_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (cmd.tbl_wr),
        .i_wr_item (i_in_data),
        .i_rd_en   (cmd.rd_en),
        .i_rd_addr (cmd.rd_addr),
        .o_rd_row  (rd_row),
        .o_rd_len  (rd_len)
    );

    // suffix match, count history and saturating accumulate
    psc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_char      (i_in_data.char_code),
        .i_rd_row    (rd_row),
        .i_rd_len    (rd_len),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
